FILE: hdl/pal_pkg.sv
// types and constants shared by the positional array list blocks
package pal_pkg;

   localparam int POS_W      = 7;
   localparam int VAL_W      = 32;
   localparam int STAT_W     = 3;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_DUMP   = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 3'd0,
      ST_APPENDED   = 3'd1,
      ST_REMOVE_REJ = 3'd2,
      ST_FULL       = 3'd3,
      ST_EMPTY      = 3'd4
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_DUMP
   } back_state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      op_type             op;
      logic [POS_W-1:0]   position;
      logic [VAL_W-1:0]   item_value;
   } cmd_type;

endpackage

FILE: hdl/pal_front.sv
// front end: takes request words, decodes the action and queues commands
module pal_front
   import pal_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output cmd_type               cmd
);

   cmd_type    q_ff [2];
   cmd_type    new_cmd;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign req_tready = (fill_ff != 2'd2);
   assign cmd_valid  = (fill_ff != 2'd0);
   assign cmd        = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      new_cmd.op         = op_type'(req_tuser);
      new_cmd.position   = req_tdata[POS_W-1:0];
      new_cmd.item_value = req_tdata[POS_W+VAL_W-1:POS_W];
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: hdl/pal_back.sv
// back end: cell chain holding the list, count, dump sequencer and result register
module pal_back
   import pal_pkg::*;
#(
   parameter int CAPACITY = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  cmd_type               cmd,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STAT_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [VAL_W-1:0]  cells_ff [CAPACITY];
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     dump_idx_ff, dump_idx_in;
   back_state_type    state_ff, state_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [POS_W-1:0]  cnt_out_ff, cnt_out_in;
   logic [POS_W-1:0]  pos_out_ff, pos_out_in;
   logic [VAL_W-1:0]  val_out_ff, val_out_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic              cmd_take;
   logic              emit;
   logic              full;
   logic              pos_ok;
   logic [POS_W-1:0]  pos_m1;
   logic [CW-1:0]     idx_p1;
   logic [CW-1:0]     count_m1;
   logic              dump_last;
   cell_op_type       cell_op;
   logic [CW-1:0]     cell_k;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign cmd_take  = cmd_valid && cmd_ready;
   assign full      = (count_ff == CW'(CAPACITY));
   assign pos_ok    = (cmd.position != '0) && (cmd.position <= POS_W'(count_ff));
   assign pos_m1    = cmd.position - POS_W'(1);
   assign idx_p1    = dump_idx_ff + CW'(1);
   assign count_m1  = count_ff - CW'(1);
   assign dump_last = (idx_p1 == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_take && cmd.op == OP_DUMP && count_ff != '0) begin
               state_in = BK_DUMP;
            end
         end
         BK_DUMP: begin
            if (out_free && dump_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      cmd_ready   = 1'b0;
      emit        = 1'b0;
      status_in   = ST_OK;
      cnt_out_in  = cnt_out_ff;
      pos_out_in  = '0;
      val_out_in  = '0;
      last_in     = 1'b1;
      count_in    = count_ff;
      dump_idx_in = dump_idx_ff;
      cell_op     = CELL_HOLD;
      cell_k      = count_ff;
      case (state_ff)
         BK_IDLE: begin
            cmd_ready = out_free;
            if (cmd_valid && out_free) begin
               emit = 1'b1;
               case (cmd.op)
                  OP_APPEND: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        cell_op  = CELL_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        cell_op  = CELL_INSERT;
                        count_in = count_ff + CW'(1);
                        if (pos_ok) begin
                           cell_k = pos_m1[CW-1:0];
                        end else begin
                           status_in = ST_APPENDED;
                        end
                     end
                  end
                  OP_REMOVE: begin
                     if (pos_ok) begin
                        cell_op  = CELL_REMOVE;
                        cell_k   = pos_m1[CW-1:0];
                        count_in = count_m1;
                     end else begin
                        status_in = ST_REMOVE_REJ;
                     end
                  end
                  OP_DUMP: begin
                     dump_idx_in = '0;
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        emit = 1'b0;
                     end
                  end
                  default: emit = 1'b0;
               endcase
               cnt_out_in = POS_W'(count_in);
            end
         end
         BK_DUMP: begin
            if (out_free) begin
               emit        = 1'b1;
               cnt_out_in  = POS_W'(count_ff);
               pos_out_in  = POS_W'(idx_p1);
               val_out_in  = cells_ff[0];
               last_in     = dump_last;
               dump_idx_in = idx_p1;
               cell_op     = CELL_ROTATE;
            end
         end
         default: ;
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);
   end

   // one cell per entry, each looking at its neighbors, the command value and cell 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      logic [VAL_W-1:0] prev_val;
      logic [VAL_W-1:0] next_val;
      logic [VAL_W-1:0] cell_in;

      if (i == 0) begin : g_first
         assign prev_val = cmd.item_value;
      end else begin : g_mid
         assign prev_val = cells_ff[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_val = cells_ff[i];
      end else begin : g_inner
         assign next_val = cells_ff[i+1];
      end

      always_comb begin
         cell_in = cells_ff[i];
         case (cell_op)
            CELL_INSERT: begin
               if (IDX == cell_k) begin
                  cell_in = cmd.item_value;
               end else if (IDX > cell_k) begin
                  cell_in = prev_val;
               end
            end
            CELL_REMOVE: begin
               if (IDX >= cell_k) begin
                  cell_in = next_val;
               end
            end
            CELL_ROTATE: begin
               if (IDX == count_m1) begin
                  cell_in = cells_ff[0];
               end else if (IDX < count_m1) begin
                  cell_in = next_val;
               end
            end
            default: cell_in = cells_ff[i];
         endcase
      end

      always_ff @(posedge clock) begin
         cells_ff[i] <= cell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff  <= status_in;
         cnt_out_ff <= cnt_out_in;
         pos_out_ff <= pos_out_in;
         val_out_ff <= val_out_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-VAL_W-2*POS_W){1'b0}}, val_out_ff, pos_out_ff, cnt_out_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: hdl/positional_array_list_core.sv
// top level of the positional array list: command queue front end and cell chain back end
//
//  channel  direction  words per request        content
//  req      in         1                        action, position, value
//  rsp      out        1, or count for a dump   status, count, position, value, last
//
//  append, insert and remove update the cell chain and the result register together as they leave the queue
//  a dump is taken, then the rotating cell chain gives one entry per cycle unless rsp stalls
//  the two-entry queue takes requests while the back end works or the rsp side stalls, until full
//  reset clears the count, the queue and the result valid flag; cells and result fields hold no reset value
module positional_array_list_core
   import pal_pkg::*;
#(
   parameter int CAPACITY = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // position, item_value, zero pad
   input  logic [1:0]            req_tuser,  // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // entry_count, entry_position, entry_value, zero pad
   output logic [STAT_W-1:0]     rsp_tuser,  // status
   output logic                  rsp_tlast
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   pal_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   pal_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
